### sv/lgrs_pkg.sv
package lgrs_pkg;

  localparam int ROW_W       = 64;
  localparam int WIDTH_CFG_W = 7;
  localparam int HEIGHT_CFG_W = 11;
  localparam int ROW_IDX_W   = 10;
  localparam int HEIGHT_LIMIT = 1024;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_IN_USE  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_IN_USE = 4'd1;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 7'd64;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 11'd1024;
  localparam int MIN_DIM = 3;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  localparam int OUT_PAYLOAD_W = ROW_W + ROW_IDX_W;
  localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_PAYLOAD_W;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef struct packed {
    logic                 last;
    logic [ROW_IDX_W-1:0] idx;
    logic [ROW_W-1:0]     cells;
  } result_t;

  typedef struct packed {
    logic main;
    logic last;
  } push_t;

endpackage

### sv/life_generation_row_stream_top.sv
// One generation of Life (birth on 3, survival on 2 or 3) over a board that
// arrives one packed row per transaction, row 0 first. Row r lets the block
// emit next-generation row r-1; the final row of the board also emits the
// all-dead last row with tlast set, so a board of H rows gives H output
// transactions. Frame cells and bits at or beyond the width in use come out
// dead. The 62 interior cells are evaluated by parallel lanes in the accept
// cycle and the results enter a four-entry output queue, so one row is taken
// per cycle while the queue has room; the final row's second output is absorbed
// by the queue because row 0 of the next board emits nothing, so a continuous
// stream with m_tready high never stalls. s_tready depends only on queue fill.
module life_generation_row_stream_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lgrs_pkg::ROW_W-1:0]          s_tdata,   // row_cells
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lgrs_pkg::OUT_TDATA_W-1:0]    m_tdata,   // next_row_cells, row_index
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lgrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lgrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RW  = lgrs_pkg::ROW_W;
  localparam int WCW = lgrs_pkg::WIDTH_CFG_W;
  localparam int HCW = lgrs_pkg::HEIGHT_CFG_W;
  localparam int IW  = lgrs_pkg::ROW_IDX_W;
  localparam int WIDTH_CAP  = (MAX_WIDTH > RW) ? RW : MAX_WIDTH;
  localparam int HEIGHT_CAP = (MAX_HEIGHT > lgrs_pkg::HEIGHT_LIMIT) ?
                              lgrs_pkg::HEIGHT_LIMIT : MAX_HEIGHT;

  logic [WCW-1:0] width_in_use;
  logic [HCW-1:0] height_in_use;
  logic [IW-1:0]  rows_seen;
  logic [RW-1:0]  row_above;
  logic [RW-1:0]  row_two_above;

  logic [WCW-1:0] width_eff;
  logic [HCW-1:0] height_eff;
  logic [IW-1:0]  last_row;
  logic [IW-1:0]  r;
  logic [RW-1:0]  cur;
  logic [RW-1:0]  evolved;
  logic           accept;
  logic           room;

  lgrs_pkg::push_t   push;
  lgrs_pkg::result_t main_data;
  lgrs_pkg::result_t last_data;
  lgrs_pkg::result_t out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= lgrs_pkg::WIDTH_RESET;
      height_in_use <= lgrs_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == lgrs_pkg::REG_WIDTH_IN_USE) begin
        width_in_use <= cfg_data[WCW-1:0];
      end else if (cfg_index == lgrs_pkg::REG_HEIGHT_IN_USE) begin
        height_in_use <= cfg_data[HCW-1:0];
      end
    end
  end

  always_comb begin
    if (width_in_use < WCW'(lgrs_pkg::MIN_DIM)) begin
      width_eff = WCW'(lgrs_pkg::MIN_DIM);
    end else if (width_in_use > WCW'(WIDTH_CAP)) begin
      width_eff = WCW'(WIDTH_CAP);
    end else begin
      width_eff = width_in_use;
    end
    if (height_in_use < HCW'(lgrs_pkg::MIN_DIM)) begin
      height_eff = HCW'(lgrs_pkg::MIN_DIM);
    end else if (height_in_use > HCW'(HEIGHT_CAP)) begin
      height_eff = HCW'(HEIGHT_CAP);
    end else begin
      height_eff = height_in_use;
    end
  end

  assign last_row = IW'(height_eff - HCW'(1));
  assign r        = (rows_seen > last_row) ? last_row : rows_seen;
  assign cur      = s_tdata & ~({RW{1'b1}} << width_eff);

  lgrs_row_eval u_eval (
    .above     (row_two_above),
    .mid       (row_above),
    .below     (cur),
    .width_eff (width_eff),
    .next_row  (evolved)
  );

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  assign push.main = accept && (r != '0);
  assign push.last = accept && (r == last_row);

  assign main_data.last  = 1'b0;
  assign main_data.idx   = r - IW'(1);
  assign main_data.cells = (r >= IW'(2)) ? evolved : '0;

  assign last_data.last  = 1'b1;
  assign last_data.idx   = last_row;
  assign last_data.cells = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_seen     <= '0;
      row_above     <= '0;
      row_two_above <= '0;
    end else if (accept) begin
      row_two_above <= row_above;
      row_above     <= cur;
      rows_seen     <= (r == last_row) ? '0 : r + IW'(1);
    end
  end

  lgrs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .main_data (main_data),
    .last_data (last_data),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {{lgrs_pkg::OUT_PAD_W{1'b0}}, out_data.idx, out_data.cells};
  assign m_tlast = out_data.last;

endmodule

### sv/lgrs_lane.sv
module lgrs_lane (
  input  logic [7:0] nbr,
  input  logic       center,
  output logic       next
);

  logic [3:0] count;

  always_comb begin
    count = '0;
    for (int k = 0; k < 8; k++) begin
      count = count + 4'(nbr[k]);
    end
  end

  assign next = (count == lgrs_pkg::BIRTH_COUNT) ||
                (center && (count == lgrs_pkg::SURVIVE_COUNT));

endmodule

### sv/lgrs_row_eval.sv
module lgrs_row_eval (
  input  logic [lgrs_pkg::ROW_W-1:0]       above,
  input  logic [lgrs_pkg::ROW_W-1:0]       mid,
  input  logic [lgrs_pkg::ROW_W-1:0]       below,
  input  logic [lgrs_pkg::WIDTH_CFG_W-1:0] width_eff,
  output logic [lgrs_pkg::ROW_W-1:0]       next_row
);

  localparam int W = lgrs_pkg::ROW_W;

  logic [W-1:0] lane_bits;
  logic [W-1:0] interior_mask;

  assign lane_bits[0]   = 1'b0;
  assign lane_bits[W-1] = 1'b0;

  for (genvar i = 1; i < W - 1; i++) begin : g_lane
    lgrs_lane u_lane (
      .nbr    ({above[i+1], above[i], above[i-1], mid[i+1], mid[i-1],
                below[i+1], below[i], below[i-1]}),
      .center (mid[i]),
      .next   (lane_bits[i])
    );
  end

  // keep columns 1 .. width-2
  assign interior_mask = ~({W{1'b1}} << (width_eff - lgrs_pkg::WIDTH_CFG_W'(1)))
                         & ~W'(1);
  assign next_row = lane_bits & interior_mask;

endmodule

### sv/lgrs_outq.sv
module lgrs_outq (
  input  logic              clk,
  input  logic              rst,
  input  lgrs_pkg::push_t   push,
  input  lgrs_pkg::result_t main_data,
  input  lgrs_pkg::result_t last_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output lgrs_pkg::result_t out_data
);

  localparam int PW = lgrs_pkg::OUTQ_PTR_W;
  localparam int CW = lgrs_pkg::OUTQ_CNT_W;

  lgrs_pkg::result_t mem [lgrs_pkg::OUTQ_DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_plus1;
  logic [1:0]    n_push;
  logic          pop;

  assign wr_ptr_plus1 = wr_ptr + PW'(1);
  assign n_push       = 2'(push.main) + 2'(push.last);
  assign pop          = out_valid && out_ready;
  assign out_valid    = (count != '0);
  assign out_data     = mem[rd_ptr];
  assign room         = (count <= CW'(lgrs_pkg::OUTQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.main) begin
      mem[wr_ptr] <= main_data;
    end
    if (push.last) begin
      mem[wr_ptr_plus1] <= last_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + CW'(n_push) - CW'(pop);
    end
  end

endmodule
